### rtl/arba_pkg.sv
`default_nettype none

package arba_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int CNT_W       = 16;
  localparam int ALIGN_W     = 16;
  localparam int HEAP_W      = 16;
  localparam int ADDR_W      = 32;
  localparam int OP_W        = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int WIDE_W      = ((OFFSET_BITS > CNT_W + 1) ? OFFSET_BITS : CNT_W + 1) + 2;
  localparam int STEP_W      = $clog2(CNT_W + 1);

  localparam int IN_FIELDS_W  = OP_W + CNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + ADDR_W + 4 * CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [OFFSET_BITS-1:0] ofs_t;
  typedef logic [WIDE_W-1:0]      wide_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [ALIGN_W-1:0]     align_t;
  typedef logic [HEAP_W-1:0]      heap_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [STEP_W-1:0]      step_t;

  localparam ofs_t OFS_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_GET      = 3'd0,
    OP_TAKE     = 3'd1,
    OP_UNTAKE   = 3'd2,
    OP_RETURN   = 3'd3,
    OP_FREE_ALL = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_HEAP  = 2'd1,
    REG_ALIGN = 2'd2
  } reg_e;

  typedef struct packed {
    addr_t  base_address;
    heap_t  heap_size;
    align_t alignment;
  } cfg_t;

  typedef struct packed {
    ofs_t next_offset;
    ofs_t bytes_in_use;
    ofs_t peak_seen;
  } alloc_state_t;

  typedef struct packed {
    cnt_t  peak_request;
    cnt_t  bytes_unused;
    cnt_t  bytes_used;
    cnt_t  bytes_free;
    addr_t block_address;
    logic  success;
  } result_t;

  function automatic ofs_t sat_ofs(wide_t v);
    return (v > wide_t'(OFS_MAX)) ? OFS_MAX : ofs_t'(v);
  endfunction

endpackage

`default_nettype wire

### rtl/arba_divu.sv
`default_nettype none

module arba_divu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire arba_pkg::cnt_t    dividend_i,
  input  wire arba_pkg::align_t  divisor_i,
  output logic                   done_o,
  output arba_pkg::align_t       rem_o
);

  arba_pkg::align_t rem_q, rem_d;
  arba_pkg::cnt_t   dvd_q, dvd_d;
  arba_pkg::step_t  step_q, step_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [arba_pkg::ALIGN_W:0] trial;

  always_comb begin
    trial  = {rem_q, dvd_q[arba_pkg::CNT_W-1]};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      step_d = arba_pkg::step_t'(arba_pkg::CNT_W);
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = arba_pkg::align_t'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = arba_pkg::align_t'(trial);
      end
      dvd_d  = {dvd_q[arba_pkg::CNT_W-2:0], 1'b0};
      step_d = step_q - arba_pkg::step_t'(1);
      if (step_q == arba_pkg::step_t'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### rtl/arba_alloc.sv
`default_nettype none

module arba_alloc (
  input  wire arba_pkg::op_e           op_i,
  input  wire arba_pkg::cnt_t          cnt_i,
  input  wire arba_pkg::align_t        rem_i,
  input  wire arba_pkg::cfg_t          cfg_i,
  input  wire arba_pkg::alloc_state_t  st_i,
  output arba_pkg::alloc_state_t       st_o,
  output arba_pkg::result_t            res_o
);

  arba_pkg::wide_t a_eff, r_w, cnt_w, n_up, n_dn, heap_w;
  arba_pkg::wide_t nxt_w, use_w, peak_w, tail, sum_use, where_w, new_nxt, new_use;
  arba_pkg::ofs_t  nxt_bump;
  logic            usable, ok;

  always_comb begin
    a_eff   = (cfg_i.alignment == '0) ? arba_pkg::wide_t'(1) : arba_pkg::wide_t'(cfg_i.alignment);
    r_w     = arba_pkg::wide_t'(rem_i);
    cnt_w   = arba_pkg::wide_t'(cnt_i);
    n_up    = (r_w == '0) ? cnt_w : cnt_w + a_eff - r_w;
    n_dn    = cnt_w - r_w;
    heap_w  = arba_pkg::wide_t'(cfg_i.heap_size);
    nxt_w   = arba_pkg::wide_t'(st_i.next_offset);
    use_w   = arba_pkg::wide_t'(st_i.bytes_in_use);
    peak_w  = arba_pkg::wide_t'(st_i.peak_seen);
    usable  = (cfg_i.base_address != '0) && (cfg_i.heap_size != '0) &&
              ((cfg_i.alignment == arba_pkg::align_t'(1)) ||
               (cfg_i.alignment == arba_pkg::align_t'(2)) ||
               (cfg_i.alignment[1:0] == 2'b00));
    tail    = (heap_w > nxt_w) ? heap_w - nxt_w : '0;
    sum_use = use_w + n_up;
    nxt_bump = arba_pkg::sat_ofs(nxt_w + n_up);
    if (arba_pkg::wide_t'(nxt_bump) > heap_w) begin
      nxt_bump = arba_pkg::ofs_t'(cfg_i.heap_size);
    end

    st_o    = st_i;
    ok      = 1'b0;
    where_w = '0;
    unique case (op_i)
      arba_pkg::OP_GET: begin
        if (usable && (n_up != '0) && (tail >= n_up)) begin
          ok               = 1'b1;
          where_w          = nxt_w;
          st_o.next_offset = nxt_bump;
        end
      end
      arba_pkg::OP_TAKE: begin
        if (usable) begin
          if (sum_use > peak_w) begin
            st_o.peak_seen = arba_pkg::sat_ofs(sum_use);
          end
          if ((n_up != '0) && (n_up <= heap_w) && (sum_use < heap_w)) begin
            ok = 1'b1;
            if (tail < n_up) begin
              st_o.bytes_in_use = arba_pkg::sat_ofs(sum_use + tail);
              st_o.next_offset  = arba_pkg::sat_ofs(n_up);
            end else begin
              where_w           = nxt_w;
              st_o.next_offset  = nxt_bump;
              st_o.bytes_in_use = arba_pkg::sat_ofs(sum_use);
            end
          end
        end
      end
      arba_pkg::OP_UNTAKE: begin
        st_o.next_offset  = (nxt_w > n_dn) ? arba_pkg::ofs_t'(nxt_w - n_dn) : '0;
        st_o.bytes_in_use = (use_w > n_dn) ? arba_pkg::ofs_t'(use_w - n_dn) : '0;
      end
      arba_pkg::OP_RETURN: begin
        st_o.bytes_in_use = (use_w > n_up) ? arba_pkg::ofs_t'(use_w - n_up) : '0;
      end
      arba_pkg::OP_FREE_ALL: begin
        st_o.next_offset  = '0;
        st_o.bytes_in_use = '0;
        st_o.peak_seen    = '0;
      end
      default: begin
      end
    endcase

    new_nxt = arba_pkg::wide_t'(st_o.next_offset);
    new_use = arba_pkg::wide_t'(st_o.bytes_in_use);
    res_o.success       = ok;
    res_o.block_address = ok ? cfg_i.base_address + arba_pkg::addr_t'(where_w) : '0;
    res_o.bytes_free    = (heap_w > new_nxt) ? arba_pkg::cnt_t'(heap_w - new_nxt) : '0;
    res_o.bytes_used    = arba_pkg::cnt_t'(st_o.bytes_in_use);
    res_o.bytes_unused  = (heap_w > new_use) ? arba_pkg::cnt_t'(heap_w - new_use) : '0;
    res_o.peak_request  = arba_pkg::cnt_t'(st_o.peak_seen);
  end

endmodule

`default_nettype wire

### rtl/aligned_ring_bump_allocator.sv
// Aligned ring bump allocator: hands out aligned blocks from one region of memory.
// The user must write configuration via cfg_we_i, cfg_idx_i and cfg_data_i while the block
// is idle (the block does not enforce it): index 0 base address, 1 heap size, 2 alignment.
// Requests arrive as beats on the s_axis channel (opcode and byte count) and each one
// produces exactly one result beat on the m_axis channel with the success flag, the block
// address and the free, used, unused and peak byte counts after the update.
// After a request beat is accepted, a shared restoring divider finds the byte count modulo
// the alignment, one quotient bit per cycle; the allocator state and the result register
// are updated once the divider has finished and the output register is free. Only one
// request is worked on at a time: s_axis_tready is low while a request is being worked on.
// The result sits in an output register, so a new request is accepted while the previous
// result still waits; if the receiver stalls past the end of the next computation, that
// computation holds until the output register is free.
// Reset clears the allocator state, the base address and heap size, and sets the
// alignment to one; no result is pending after reset.
`default_nettype none

module aligned_ring_bump_allocator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [arba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [arba_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0 up: opcode, byte_count.
  input  wire logic [arba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // Fields from bit 0 up: success, block_address, bytes_free, bytes_used,
  // bytes_unused, peak_request.
  output logic [arba_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e                 state_q;
  arba_pkg::cfg_t         cfg_q;
  arba_pkg::alloc_state_t st_q, st_d;
  arba_pkg::result_t      res_q, res_d;
  arba_pkg::op_e          op_q;
  arba_pkg::cnt_t         cnt_q;
  logic                   m_valid_q;
  logic                   in_beat;
  logic                   div_done;
  logic                   commit;
  arba_pkg::align_t       divisor;
  arba_pkg::align_t       rem;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == ST_DIV) && div_done && (!m_valid_q || m_axis_tready);
  assign divisor       = (cfg_q.alignment == '0) ? arba_pkg::align_t'(1) : cfg_q.alignment;

  arba_divu u_divu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_beat),
    .dividend_i (s_axis_tdata[arba_pkg::OP_W +: arba_pkg::CNT_W]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  arba_alloc u_alloc (
    .op_i  (op_q),
    .cnt_i (cnt_q),
    .rem_i (rem),
    .cfg_i (cfg_q),
    .st_i  (st_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      cfg_q.base_address <= '0;
      cfg_q.heap_size    <= '0;
      cfg_q.alignment    <= arba_pkg::align_t'(1);
      st_q               <= '0;
      m_valid_q          <= 1'b0;
      res_q              <= '0;
      op_q               <= arba_pkg::OP_GET;
      cnt_q              <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (arba_pkg::reg_e'(cfg_idx_i))
          arba_pkg::REG_BASE:  cfg_q.base_address <= cfg_data_i;
          arba_pkg::REG_HEAP:  cfg_q.heap_size    <= arba_pkg::heap_t'(cfg_data_i);
          arba_pkg::REG_ALIGN: cfg_q.alignment    <= arba_pkg::align_t'(cfg_data_i);
          default: begin
          end
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            op_q    <= arba_pkg::op_e'(s_axis_tdata[arba_pkg::OP_W-1:0]);
            cnt_q   <= s_axis_tdata[arba_pkg::OP_W +: arba_pkg::CNT_W];
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (commit) begin
            st_q    <= st_d;
            res_q   <= res_d;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(arba_pkg::OUT_TDATA_W - arba_pkg::OUT_FIELDS_W){1'b0}},
                          res_q.peak_request, res_q.bytes_unused, res_q.bytes_used,
                          res_q.bytes_free, res_q.block_address, res_q.success};

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("request accepted while a computation was running");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(commit))
    else $error("result raised without a finished computation");

  a_success_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_valid_q) && res_q.success) |->
      (op_q == arba_pkg::OP_GET || op_q == arba_pkg::OP_TAKE))
    else $error("success reported for an opcode that cannot allocate");

  a_free_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (arba_pkg::heap_t'(res_q.bytes_free) <= cfg_q.heap_size))
    else $error("free byte count exceeds the heap size");

endmodule

`default_nettype wire
